// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks shared by the RTL; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, cut out while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, cut out while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/qahm_pkg.sv =====
// ----------------------------------------------------------------------------
// qahm_pkg
// Shared widths, codes, reset values and helpers for the altitude-hold mixer.
// ----------------------------------------------------------------------------
package qahm_pkg;

  // Field widths
  localparam int VAL_W   = 24;   // Q8.16 values, gains and base thrust
  localparam int STEP_W  = 17;   // setpoint step
  localparam int KEY_W   = 4;
  localparam int DRV_W   = 25;   // Q9.16 drives
  localparam int MAG_W   = 17;   // clamped magnitudes, up to 1.0
  localparam int ACC_W   = 28;   // exact drive sum before saturation
  localparam int NUM_DRV = 4;

  // Bit-serial multiplier operand widths
  localparam int MUL_MD_W = 34;  // multiplicand: error magnitude, its square or a gain
  localparam int MUL_MR_W = 17;  // multiplier: a clamped magnitude
  localparam int MUL_P_W  = MUL_MD_W + MUL_MR_W;

  localparam logic [MAG_W-1:0] ONE_Q16 = 17'h10000;

  // Register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_THRUST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_STEP = 3'd6;

  // Register reset values
  localparam logic [VAL_W-1:0]  RST_BASE_THRUST   = 24'd4489216;
  localparam logic [VAL_W-1:0]  RST_ALT_OFFSET    = 24'd39322;
  localparam logic [VAL_W-1:0]  RST_VERTICAL_GAIN = 24'd196608;
  localparam logic [VAL_W-1:0]  RST_ROLL_GAIN     = 24'd3276800;
  localparam logic [VAL_W-1:0]  RST_PITCH_GAIN    = 24'd1966080;
  localparam logic [VAL_W-1:0]  RST_YAW_GAIN      = 24'd655360;
  localparam logic [STEP_W-1:0] RST_SETPOINT_STEP = 17'd3277;
  localparam logic [VAL_W-1:0]  RST_ALT_TARGET    = 24'd65536;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_PITCH_UP   = 4'd0;
  localparam logic [KEY_W-1:0] KEY_PITCH_DOWN = 4'd1;
  localparam logic [KEY_W-1:0] KEY_ROLL_UP    = 4'd2;
  localparam logic [KEY_W-1:0] KEY_ROLL_DOWN  = 4'd3;
  localparam logic [KEY_W-1:0] KEY_YAW_UP     = 4'd4;
  localparam logic [KEY_W-1:0] KEY_YAW_DOWN   = 4'd5;
  localparam logic [KEY_W-1:0] KEY_ALT_UP     = 4'd6;
  localparam logic [KEY_W-1:0] KEY_ALT_DOWN   = 4'd7;

  // Per-drive negate masks, bit 0 front left .. bit 3 rear right
  localparam logic [NUM_DRV-1:0] NEG_VERT  = 4'b0110;
  localparam logic [NUM_DRV-1:0] NEG_ROLL  = 4'b0011;
  localparam logic [NUM_DRV-1:0] NEG_PITCH = 4'b1010;
  localparam logic [NUM_DRV-1:0] NEG_YAW   = 4'b1111;

  // Mixer control
  typedef struct packed {
    logic               init;      // load accumulators with +/- base thrust
    logic               add;       // add the term into each accumulator
    logic [NUM_DRV-1:0] neg_mask;  // per-drive subtract
  } mix_ctrl_t;

  // Magnitude of a setpoint clamped to +/- 1.0
  function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [VAL_W-1:0] sp);
    logic [VAL_W-1:0] mag;
    mag = sp[VAL_W-1] ? VAL_W'(-sp) : VAL_W'(sp);
    return (mag > VAL_W'(ONE_Q16)) ? ONE_Q16 : mag[MAG_W-1:0];
  endfunction

  // Step a setpoint up or down, saturating at the Q8.16 range
  function automatic logic signed [VAL_W-1:0] nudge(input logic signed [VAL_W-1:0] sp,
                                                    input logic [STEP_W-1:0] step,
                                                    input logic up);
    logic signed [VAL_W+1:0] dlt;
    logic signed [VAL_W+1:0] sum;
    dlt = $signed({{(VAL_W+2-STEP_W){1'b0}}, step});
    sum = $signed({{2{sp[VAL_W-1]}}, sp}) + (up ? dlt : -dlt);
    if (sum > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (sum < -26'sd8388608) begin
      return 24'sh800000;
    end
    return sum[VAL_W-1:0];
  endfunction

  // Saturate an exact drive sum to Q9.16
  function automatic logic [DRV_W-1:0] sat_drive(input logic signed [ACC_W-1:0] acc);
    if (acc > 28'sd16777215) begin
      return 25'h0FFFFFF;
    end else if (acc < -28'sd16777216) begin
      return 25'h1000000;
    end
    return acc[DRV_W-1:0];
  endfunction

endpackage

// ===== src/quad_altitude_hold_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// quad_altitude_hold_mixer_unit
// Altitude-hold and manual-attitude motor mixer for an X quadcopter.
// ----------------------------------------------------------------------------
// A key beat (tuser low) nudges one setpoint and is done in its accept cycle,
// giving no result. A tick beat (tuser high) gives one result beat with four
// drives: the error cube, the vertical term and the roll, pitch and yaw terms
// are six passes through one bit-serial multiplier, each with its setup and
// all but the square with rounding, then the hand-off to the output register.
// The result register lets the next item be taken while a result still waits.
// Configuration writes are taken at any time but belong to idle periods.
`include "assert_macros.svh"

module quad_altitude_hold_mixer_unit import qahm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Input beats
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // [3:0] key_code, [27:4] altitude
  input  logic [0:0]           s_axis_tuser,  // [0] action
  // Result beats
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [24:0] drive_front_left, [49:25] drive_front_right,
  // [74:50] drive_rear_left, [99:75] drive_rear_right
  output logic [103:0]         m_axis_tdata,
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_NEXT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    STEP_SQUARE = 3'd0,
    STEP_CUBE   = 3'd1,
    STEP_VERT   = 3'd2,
    STEP_ROLL   = 3'd3,
    STEP_PITCH  = 3'd4,
    STEP_YAW    = 3'd5
  } step_t;

  // Configuration
  logic [VAL_W-1:0]  base_thrust;
  logic [VAL_W-1:0]  altitude_offset;
  logic [VAL_W-1:0]  vertical_gain;
  logic [VAL_W-1:0]  roll_gain;
  logic [VAL_W-1:0]  pitch_gain;
  logic [VAL_W-1:0]  yaw_gain;
  logic [STEP_W-1:0] setpoint_step;

  // Setpoints
  logic signed [VAL_W-1:0] altitude_target;
  logic signed [VAL_W-1:0] roll_setpoint;
  logic signed [VAL_W-1:0] pitch_setpoint;
  logic signed [VAL_W-1:0] yaw_setpoint;

  // Sequencer
  state_t            state;
  step_t             step;
  logic [MAG_W-1:0]  e_mag;
  logic              e_neg;
  logic [MUL_MD_W-1:0] sq;
  logic [MAG_W-1:0]  cube_mag;

  // Input fields
  logic                    action;
  logic [KEY_W-1:0]        key_code;
  logic signed [VAL_W-1:0] altitude;
  logic                    in_accept;
  logic                    tick_accept;
  logic                    key_accept;

  // Error and datapath
  logic signed [VAL_W+1:0] err_sum;
  logic [VAL_W+1:0]        err_abs;
  logic [MAG_W-1:0]        err_mag;
  logic                    mul_start;
  logic                    mul_done;
  logic [MUL_MD_W-1:0]     mul_md;
  logic [MUL_MR_W-1:0]     mul_mr;
  logic [MUL_P_W-1:0]      mul_prod;
  logic [MUL_P_W-1:0]      rnd32;
  logic [MUL_P_W-1:0]      rnd16;
  logic [NUM_DRV-1:0]      coef;
  logic                    term_neg;
  mix_ctrl_t               mix_ctrl;
  logic [NUM_DRV-1:0][DRV_W-1:0] drive;

  // Output register
  logic         out_valid;
  logic [103:0] out_data;
  logic         out_load;

  assign action   = s_axis_tuser[0];
  assign key_code = s_axis_tdata[3:0];
  assign altitude = $signed(s_axis_tdata[27:4]);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign tick_accept   = in_accept && action;
  assign key_accept    = in_accept && !action;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_thrust     <= RST_BASE_THRUST;
      altitude_offset <= RST_ALT_OFFSET;
      vertical_gain   <= RST_VERTICAL_GAIN;
      roll_gain       <= RST_ROLL_GAIN;
      pitch_gain      <= RST_PITCH_GAIN;
      yaw_gain        <= RST_YAW_GAIN;
      setpoint_step   <= RST_SETPOINT_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_THRUST:   base_thrust     <= cfg_data;
        REG_ALT_OFFSET:    altitude_offset <= cfg_data;
        REG_VERTICAL_GAIN: vertical_gain   <= cfg_data;
        REG_ROLL_GAIN:     roll_gain       <= cfg_data;
        REG_PITCH_GAIN:    pitch_gain      <= cfg_data;
        REG_YAW_GAIN:      yaw_gain        <= cfg_data;
        REG_SETPOINT_STEP: setpoint_step   <= cfg_data[STEP_W-1:0];
        default:           ;
      endcase
    end
  end

  // Key beats: nudge one setpoint, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      altitude_target <= RST_ALT_TARGET;
      roll_setpoint   <= '0;
      pitch_setpoint  <= '0;
      yaw_setpoint    <= '0;
    end else if (key_accept) begin
      case (key_code)
        KEY_PITCH_UP:   pitch_setpoint  <= nudge(pitch_setpoint, setpoint_step, 1'b1);
        KEY_PITCH_DOWN: pitch_setpoint  <= nudge(pitch_setpoint, setpoint_step, 1'b0);
        KEY_ROLL_UP:    roll_setpoint   <= nudge(roll_setpoint, setpoint_step, 1'b1);
        KEY_ROLL_DOWN:  roll_setpoint   <= nudge(roll_setpoint, setpoint_step, 1'b0);
        KEY_YAW_UP:     yaw_setpoint    <= nudge(yaw_setpoint, setpoint_step, 1'b1);
        KEY_YAW_DOWN:   yaw_setpoint    <= nudge(yaw_setpoint, setpoint_step, 1'b0);
        KEY_ALT_UP:     altitude_target <= nudge(altitude_target, setpoint_step, 1'b1);
        KEY_ALT_DOWN:   altitude_target <= nudge(altitude_target, setpoint_step, 1'b0);
        default:        ;
      endcase
    end
  end

  // Altitude error, clamped to +/- 1.0, as sign and magnitude
  assign err_sum = $signed({{2{altitude_target[VAL_W-1]}}, altitude_target})
                 - $signed({{2{altitude[VAL_W-1]}}, altitude})
                 + $signed({{2{altitude_offset[VAL_W-1]}}, altitude_offset});
  assign err_abs = err_sum[VAL_W+1] ? (VAL_W+2)'(-err_sum) : (VAL_W+2)'(err_sum);
  assign err_mag = (err_abs > (VAL_W+2)'(ONE_Q16)) ? ONE_Q16 : err_abs[MAG_W-1:0];

  // Operands, term sign and mix pattern for each pass
  always_comb begin
    mul_md   = '0;
    mul_mr   = '0;
    coef     = NEG_VERT;
    term_neg = 1'b0;
    case (step)
      STEP_SQUARE: begin
        mul_md = MUL_MD_W'(e_mag);
        mul_mr = e_mag;
      end
      STEP_CUBE: begin
        mul_md = sq;
        mul_mr = e_mag;
      end
      STEP_VERT: begin
        mul_md   = MUL_MD_W'(vertical_gain);
        mul_mr   = cube_mag;
        term_neg = e_neg;
      end
      STEP_ROLL: begin
        mul_md   = MUL_MD_W'(roll_gain);
        mul_mr   = clamp_mag(roll_setpoint);
        coef     = NEG_ROLL;
        term_neg = roll_setpoint[VAL_W-1];
      end
      STEP_PITCH: begin
        mul_md   = MUL_MD_W'(pitch_gain);
        mul_mr   = clamp_mag(pitch_setpoint);
        coef     = NEG_PITCH;
        term_neg = pitch_setpoint[VAL_W-1];
      end
      STEP_YAW: begin
        mul_md   = MUL_MD_W'(yaw_gain);
        mul_mr   = clamp_mag(yaw_setpoint);
        coef     = NEG_YAW;
        term_neg = yaw_setpoint[VAL_W-1];
      end
      default: ;
    endcase
  end

  assign mul_start = (state == ST_START);

  qahm_serial_mult #(
    .MD_W (MUL_MD_W),
    .MR_W (MUL_MR_W)
  ) u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .md_in (mul_md),
    .mr_in (mul_mr),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Round half away from zero on magnitudes
  assign rnd32 = mul_prod + (MUL_P_W'(1) << 31);
  assign rnd16 = mul_prod + (MUL_P_W'(1) << 15);

  assign mix_ctrl.init     = tick_accept;
  assign mix_ctrl.add      = (state == ST_NEXT) && (step != STEP_SQUARE)
                             && (step != STEP_CUBE);
  assign mix_ctrl.neg_mask = tick_accept ? NEG_VERT : (coef ^ {NUM_DRV{term_neg}});

  qahm_mixer u_mixer (
    .clk   (clk),
    .ctrl  (mix_ctrl),
    .base  (base_thrust),
    .term  (rnd16[DRV_W+15:16]),
    .drive (drive)
  );

  // Tick sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_SQUARE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (tick_accept) begin
            state <= ST_START;
            step  <= STEP_SQUARE;
          end
        end
        ST_START: state <= ST_RUN;
        ST_RUN: begin
          if (mul_done) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (step == STEP_YAW) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_START;
            step  <= step_t'(step + 3'd1);
          end
        end
        ST_FLUSH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture error and intermediate powers
  always_ff @(posedge clk) begin
    if (tick_accept) begin
      e_mag <= err_mag;
      e_neg <= err_sum[VAL_W+1];
    end
    if (state == ST_NEXT) begin
      if (step == STEP_SQUARE) begin
        sq <= mul_prod[MUL_MD_W-1:0];
      end
      if (step == STEP_CUBE) begin
        cube_mag <= rnd32[MAG_W+31:32];
      end
    end
  end

  // Result register
  assign out_load = (state == ST_FLUSH) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'b0, drive[3], drive[2], drive[1], drive[0]};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `ASSERT_IMPLY(a_ready_only_idle, clk, rst, s_axis_tready, !mul_done && !out_load)
  `ASSERT_NEXT(a_tick_starts, clk, rst, tick_accept, state == ST_START && step == STEP_SQUARE)
  `ASSERT_IMPLY(a_done_in_run, clk, rst, mul_done, state == ST_RUN)

endmodule

// ===== src/qahm_serial_mult.sv =====
// ----------------------------------------------------------------------------
// qahm_serial_mult
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qahm_serial_mult import qahm_pkg::*; #(
  parameter int MD_W = MUL_MD_W,
  parameter int MR_W = MUL_MR_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MD_W-1:0]      md_in,
  input  logic [MR_W-1:0]      mr_in,
  output logic                 done,
  output logic [MD_W+MR_W-1:0] prod
);

  localparam int CNT_W = (MR_W > 1) ? $clog2(MR_W) : 1;

  logic [MD_W-1:0]  md;
  logic [MR_W-1:0]  mr;
  logic [MD_W-1:0]  hi;
  logic [MR_W-1:0]  lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MD_W:0]    sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (mr[0] ? {1'b0, md} : {(MD_W+1){1'b0}});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Shift the partial product right, one retired bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      md <= md_in;
      mr <= mr_in;
      hi <= '0;
      lo <= '0;
    end else if (busy) begin
      hi <= sum[MD_W:1];
      lo <= {sum[0], lo[MR_W-1:1]};
      mr <= mr >> 1;
    end
  end

  assign prod = {hi, lo};

  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

endmodule

// ===== src/qahm_mixer.sv =====
// ----------------------------------------------------------------------------
// qahm_mixer
// Four drive accumulators: load base thrust, add signed terms, saturate.
// ----------------------------------------------------------------------------
module qahm_mixer import qahm_pkg::*; (
  input  logic                          clk,
  input  mix_ctrl_t                     ctrl,
  input  logic [VAL_W-1:0]              base,
  input  logic [DRV_W-1:0]              term,
  output logic [NUM_DRV-1:0][DRV_W-1:0] drive
);

  logic signed [ACC_W-1:0] acc [NUM_DRV];
  logic signed [ACC_W-1:0] base_s;
  logic signed [ACC_W-1:0] term_s;

  assign base_s = $signed({{(ACC_W-VAL_W){1'b0}}, base});
  assign term_s = $signed({{(ACC_W-DRV_W){1'b0}}, term});

  for (genvar i = 0; i < NUM_DRV; i++) begin : g_lane
    // Load or accumulate one drive
    always_ff @(posedge clk) begin
      if (ctrl.init) begin
        acc[i] <= ctrl.neg_mask[i] ? -base_s : base_s;
      end else if (ctrl.add) begin
        acc[i] <= acc[i] + (ctrl.neg_mask[i] ? -term_s : term_s);
      end
    end

    assign drive[i] = sat_drive(acc[i]);
  end

endmodule

// ===== bench/qahm_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qahm_drive_checker
// Watches the input, result and configuration ports of the altitude-hold
// mixer, keeps its own copy of the setpoints and registers, predicts the four
// motor drives of every control tick and compares each result beat with the
// oldest prediction.
// ----------------------------------------------------------------------------
module qahm_drive_checker import qahm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // [3:0] key_code, [27:4] altitude
  input  logic [0:0]           s_axis_tuser,  // [0] action
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [24:0] drive_front_left, [49:25] drive_front_right,
  // [74:50] drive_rear_left, [99:75] drive_rear_right
  input  logic [103:0]         m_axis_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   outstanding
);

  localparam longint SP_TOP     = 8388607;
  localparam longint SP_BOTTOM  = -8388608;
  localparam longint DRV_TOP    = 16777215;
  localparam longint DRV_BOTTOM = -16777216;
  localparam longint UNITY      = 65536;

  // Four drives in port order, front left in the lowest bits
  typedef struct packed {
    logic [DRV_W-1:0] rear_right;
    logic [DRV_W-1:0] rear_left;
    logic [DRV_W-1:0] front_right;
    logic [DRV_W-1:0] front_left;
  } drive_set_t;

  drive_set_t pending_drives[$];

  // Register copy
  logic [VAL_W-1:0]        base_thrust;
  logic signed [VAL_W-1:0] altitude_offset;
  logic [VAL_W-1:0]        vertical_gain;
  logic [VAL_W-1:0]        roll_gain;
  logic [VAL_W-1:0]        pitch_gain;
  logic [VAL_W-1:0]        yaw_gain;
  logic [STEP_W-1:0]       setpoint_step;

  // Setpoint copy
  logic signed [VAL_W-1:0] altitude_target;
  logic signed [VAL_W-1:0] roll_sp;
  logic signed [VAL_W-1:0] pitch_sp;
  logic signed [VAL_W-1:0] yaw_sp;

  initial mismatch_count = 0;

  function automatic longint limit(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // One key press, saturating at the Q8.16 range
  function automatic logic signed [VAL_W-1:0] stepped(input logic signed [VAL_W-1:0] sp,
                                                      input logic up);
    longint v;
    v = longint'(sp) + (up ? longint'(setpoint_step) : -longint'(setpoint_step));
    return VAL_W'(limit(v, SP_BOTTOM, SP_TOP));
  endfunction

  // Magnitude times Q.16 gain, rounded half away from zero, sign restored
  function automatic longint scaled(input longint x, input logic [VAL_W-1:0] gain);
    longint m;
    longint r;
    m = (x < 0) ? -x : x;
    r = (m * longint'(gain) + 32768) >> 16;
    return (x < 0) ? -r : r;
  endfunction

  // Q.16 cube, rounded half away from zero, sign restored
  function automatic longint cubed(input longint e);
    longint m;
    longint r;
    m = (e < 0) ? -e : e;
    r = (m * m * m + 64'h8000_0000) >> 32;
    return (e < 0) ? -r : r;
  endfunction

  function automatic logic [DRV_W-1:0] drive_word(input longint v);
    return DRV_W'(limit(v, DRV_BOTTOM, DRV_TOP));
  endfunction

  task automatic report_field(input string name, input logic [DRV_W-1:0] want,
                              input logic [DRV_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : model
    drive_set_t want;
    drive_set_t got;
    longint e, v, r, p, y, b;
    if (rst) begin
      base_thrust     = RST_BASE_THRUST;
      altitude_offset = RST_ALT_OFFSET;
      vertical_gain   = RST_VERTICAL_GAIN;
      roll_gain       = RST_ROLL_GAIN;
      pitch_gain      = RST_PITCH_GAIN;
      yaw_gain        = RST_YAW_GAIN;
      setpoint_step   = RST_SETPOINT_STEP;
      altitude_target = RST_ALT_TARGET;
      roll_sp         = '0;
      pitch_sp        = '0;
      yaw_sp          = '0;
      pending_drives.delete();
    end else begin
      // Take configuration writes; unknown indexes change nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_THRUST:   base_thrust     = cfg_data;
          REG_ALT_OFFSET:    altitude_offset = cfg_data;
          REG_VERTICAL_GAIN: vertical_gain   = cfg_data;
          REG_ROLL_GAIN:     roll_gain       = cfg_data;
          REG_PITCH_GAIN:    pitch_gain      = cfg_data;
          REG_YAW_GAIN:      yaw_gain        = cfg_data;
          REG_SETPOINT_STEP: setpoint_step   = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      // Compare a result beat with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(drive_set_t)-1:0];
        if (pending_drives.size() == 0) begin
          $display("%0t: result beat with no tick waiting, expected none, actual %h",
                   $time, got);
          mismatch_count++;
        end else begin
          want = pending_drives.pop_front();
          report_field("drive_front_left",  want.front_left,  got.front_left);
          report_field("drive_front_right", want.front_right, got.front_right);
          report_field("drive_rear_left",   want.rear_left,   got.rear_left);
          report_field("drive_rear_right",  want.rear_right,  got.rear_right);
        end
      end

      // Advance the model on an input beat
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0]) begin
          // Control tick: error sum at full width, then clamp, cube and mix
          e = limit(longint'(altitude_target) - longint'($signed(s_axis_tdata[27:4]))
                    + longint'(altitude_offset), -UNITY, UNITY);
          v = scaled(cubed(e), vertical_gain);
          r = scaled(limit(longint'(roll_sp), -UNITY, UNITY), roll_gain);
          p = scaled(limit(longint'(pitch_sp), -UNITY, UNITY), pitch_gain);
          y = scaled(limit(longint'(yaw_sp), -UNITY, UNITY), yaw_gain);
          b = longint'(base_thrust) + v;
          want.front_left  = drive_word(b - r + p - y);
          want.front_right = drive_word(-(b + r + p + y));
          want.rear_left   = drive_word(-(b - r - p + y));
          want.rear_right  = drive_word(b + r - p - y);
          pending_drives.push_back(want);
        end else begin
          // Key event: nudge one setpoint, ignore the rest
          case (s_axis_tdata[KEY_W-1:0])
            KEY_PITCH_UP:   pitch_sp        = stepped(pitch_sp, 1'b1);
            KEY_PITCH_DOWN: pitch_sp        = stepped(pitch_sp, 1'b0);
            KEY_ROLL_UP:    roll_sp         = stepped(roll_sp, 1'b1);
            KEY_ROLL_DOWN:  roll_sp         = stepped(roll_sp, 1'b0);
            KEY_YAW_UP:     yaw_sp          = stepped(yaw_sp, 1'b1);
            KEY_YAW_DOWN:   yaw_sp          = stepped(yaw_sp, 1'b0);
            KEY_ALT_UP:     altitude_target = stepped(altitude_target, 1'b1);
            KEY_ALT_DOWN:   altitude_target = stepped(altitude_target, 1'b0);
            default: ;
          endcase
        end
      end
    end
    outstanding <= pending_drives.size();
  end

endmodule

// ===== bench/tb_quad_altitude_hold_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_altitude_hold_mixer_unit
// Drives key and tick beats into the mixer with random gaps and result-side
// stalls, steps through several register settings from the extremes through
// random ones back to the reset values, and leaves prediction and comparison
// to the drive checker.
module tb_quad_altitude_hold_mixer_unit;
  import qahm_pkg::*;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [KEY_W-1:0] KEY_FIRST_IGNORED = 4'd8;
  localparam logic [KEY_W-1:0] KEY_LAST_IGNORED  = 4'd15;

  // Altitude that zeroes the error with reset target and offset
  localparam int NEUTRAL_ALT = 104858;

  localparam int PHASE_ITEMS = 170;

  typedef enum int {SET_MAX, SET_MIN, SET_RANDOM, SET_MILD, SET_RESET} setting_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;  // [3:0] key_code, [27:4] altitude
  logic [0:0]           s_axis_tuser = '0;  // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [24:0] drive_front_left, [49:25] drive_front_right,
  // [74:50] drive_rear_left, [99:75] drive_rear_right
  logic [103:0]         m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int outstanding;
  bit quiet = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quad_altitude_hold_mixer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  qahm_drive_checker drive_check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // Give up long after the slowest correct run
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_altitude();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return VAL_W'($urandom_range(0, 400000) - 150000);
    if (r < 8) return VAL_W'($urandom);
    if (r == 8) return 24'h7FFFFF;
    return 24'h800000;
  endfunction

  // Stall the result side in random stretches
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      if (quiet) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
        hold = pick_gap();
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // Offer one beat, hold it until taken, then idle for a while
  task automatic push_item(input logic action, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] altitude);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {4'b0000, altitude, key};
    do @(posedge clk); while (!s_axis_tready);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every tick has produced its drives
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t s);
    logic [VAL_W-1:0] base, offset, vg, rg, pg, yg, stp;
    case (s)
      SET_MAX: begin
        base = 24'hFFFFFF; offset = 24'h7FFFFF;
        vg = 24'hFFFFFF; rg = 24'hFFFFFF; pg = 24'hFFFFFF; yg = 24'hFFFFFF;
        stp = 24'hFFFFFF;  // upper bits beyond the step width drop off
      end
      SET_MIN: begin
        base = '0; offset = 24'h800000;
        vg = '0; rg = '0; pg = '0; yg = '0;
        stp = '0;
      end
      SET_RANDOM: begin
        base = VAL_W'($urandom); offset = VAL_W'($urandom);
        vg = VAL_W'($urandom); rg = VAL_W'($urandom);
        pg = VAL_W'($urandom); yg = VAL_W'($urandom);
        stp = VAL_W'($urandom);
      end
      SET_MILD: begin
        base = VAL_W'($urandom_range(0, 24'h700000));
        offset = VAL_W'($urandom_range(0, 131072) - 65536);
        vg = VAL_W'($urandom_range(0, 24'h200000));
        rg = VAL_W'($urandom_range(0, 24'h400000));
        pg = VAL_W'($urandom_range(0, 24'h400000));
        yg = VAL_W'($urandom_range(0, 24'h400000));
        stp = VAL_W'($urandom_range(1000, 65536));
      end
      default: begin
        base = RST_BASE_THRUST; offset = RST_ALT_OFFSET;
        vg = RST_VERTICAL_GAIN; rg = RST_ROLL_GAIN;
        pg = RST_PITCH_GAIN; yg = RST_YAW_GAIN;
        stp = VAL_W'(RST_SETPOINT_STEP);
      end
    endcase
    write_reg(REG_UNUSED, VAL_W'($urandom));
    write_reg(REG_BASE_THRUST, base);
    write_reg(REG_ALT_OFFSET, offset);
    write_reg(REG_VERTICAL_GAIN, vg);
    write_reg(REG_ROLL_GAIN, rg);
    write_reg(REG_PITCH_GAIN, pg);
    write_reg(REG_YAW_GAIN, yg);
    write_reg(REG_SETPOINT_STEP, stp);
    cfg_we <= 1'b0;
  endtask

  // Ticks, ignored keys and runs of one key; long runs drive a setpoint
  // into saturation when the step is large
  task automatic random_run(input int count);
    int sent;
    int choice;
    int run_len;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < count) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        push_item(ACT_TICK, KEY_W'($urandom), pick_altitude());
        sent++;
      end else if (choice < 56) begin
        push_item(ACT_KEY, KEY_W'($urandom_range(KEY_FIRST_IGNORED, KEY_LAST_IGNORED)),
                  VAL_W'($urandom));
      end else begin
        key = KEY_W'($urandom_range(KEY_PITCH_UP, KEY_ALT_DOWN));
        run_len = ($urandom_range(0, 99) < 6) ? $urandom_range(30, 90)
                                              : $urandom_range(1, 4);
        repeat (run_len) push_item(ACT_KEY, key, VAL_W'($urandom));
        sent += run_len;
      end
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  initial begin : stimulus
    setting_t plan [6];
    plan = '{SET_MAX, SET_MIN, SET_RANDOM, SET_MILD, SET_RANDOM, SET_RESET};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: error clamps, zero and fractional error, every key, ignored keys
    push_item(ACT_TICK, KEY_PITCH_UP, 24'd0);
    push_item(ACT_TICK, KEY_LAST_IGNORED, 24'h7FFFFF);
    push_item(ACT_TICK, KEY_PITCH_UP, 24'h800000);
    push_item(ACT_TICK, KEY_PITCH_UP, VAL_W'(NEUTRAL_ALT));
    push_item(ACT_TICK, KEY_PITCH_UP, VAL_W'(NEUTRAL_ALT - 32768));
    push_item(ACT_TICK, KEY_PITCH_UP, VAL_W'(NEUTRAL_ALT + 1));
    push_item(ACT_TICK, KEY_PITCH_UP, VAL_W'(NEUTRAL_ALT + 45000));
    for (int k = KEY_PITCH_UP; k <= KEY_ALT_DOWN; k++) begin
      push_item(ACT_KEY, KEY_W'(k), VAL_W'($urandom));
    end
    push_item(ACT_TICK, KEY_PITCH_UP, 24'd50000);
    push_item(ACT_KEY, KEY_FIRST_IGNORED, 24'hFFFFFF);
    push_item(ACT_KEY, KEY_LAST_IGNORED, 24'h000000);
    push_item(ACT_TICK, KEY_PITCH_UP, 24'd120000);
    repeat (3) push_item(ACT_KEY, KEY_ROLL_UP, VAL_W'($urandom));
    push_item(ACT_TICK, KEY_PITCH_UP, VAL_W'(NEUTRAL_ALT));
    settle();

    // Random phases, each under its own register setting
    for (int i = 0; i < 6; i++) begin
      settle();
      apply_setting(plan[i]);
      quiet = (plan[i] == SET_MILD);
      random_run(PHASE_ITEMS);
    end
    quiet = 1'b0;

    settle();
    repeat (130) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
